[rtl/utf8d_pkg.sv]
// Shared types and constants for the UTF-8 stream decoder.
`timescale 1ns / 1ps
package utf8d_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] REPL_CP = 21'h00FFFD;

  // Sequence length codes held in the front state
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  // One decoded byte's worth of work: rep_cnt replacements, then an optional final result
  typedef struct packed {
    logic [1:0]     rep_cnt;
    logic           has_final;
    logic           final_rep;
    logic [CpW-1:0] final_cp;
  } job_t;

  localparam int unsigned JobW = $bits(job_t);

endpackage

[rtl/utf8d_fifo.sv]
// Small job queue between the decoder front and the result back end.
`timescale 1ns / 1ps
module utf8d_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             not_empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == FullCnt);
  assign not_empty = (count_r != '0);
  assign head_data = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/utf8d_front.sv]
// Decoder front: accepts bytes, tracks the open sequence and emits result jobs.
`timescale 1ns / 1ps
module utf8d_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  input  logic                in_end,
  input  logic                q_full,
  output logic                in_ready,
  output logic                job_push,
  output utf8d_pkg::job_t     job
);

  logic [2:0]                 exp_len_r, exp_len_nxt;
  logic [1:0]                 held_r, held_nxt;
  logic [utf8d_pkg::CpW-1:0]  part_r, part_nxt;

  logic                       accept;
  logic                       seq_open, is_cont;
  logic [1:0]                 held_inc;
  logic [utf8d_pkg::CpW-1:0]  part_shift;
  logic [2:0]                 lead_len;
  logic [utf8d_pkg::CpW-1:0]  lead_bits;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign seq_open = (exp_len_r != utf8d_pkg::LEN_NONE);
  assign is_cont  = (in_byte[7:6] == 2'b10);
  assign held_inc = held_r + 2'd1;
  assign part_shift = {part_r[utf8d_pkg::CpW-7:0], in_byte[5:0]};

  always_comb begin
    lead_len  = utf8d_pkg::LEN_NONE;
    lead_bits = '0;
    if (in_byte[7:5] == 3'b110) begin
      lead_len  = utf8d_pkg::LEN_TWO;
      lead_bits = {16'd0, in_byte[4:0]};
    end else if (in_byte[7:4] == 4'b1110) begin
      lead_len  = utf8d_pkg::LEN_THREE;
      lead_bits = {17'd0, in_byte[3:0]};
    end else if (in_byte[7:3] == 5'b11110) begin
      lead_len  = utf8d_pkg::LEN_FOUR;
      lead_bits = {18'd0, in_byte[2:0]};
    end
  end

  always_comb begin
    exp_len_nxt   = utf8d_pkg::LEN_NONE;
    held_nxt      = '0;
    part_nxt      = '0;
    job.rep_cnt   = '0;
    job.has_final = 1'b0;
    job.final_rep = 1'b0;
    job.final_cp  = utf8d_pkg::REPL_CP;

    if (seq_open && is_cont) begin
      if ({1'b0, held_inc} == exp_len_r - 3'd1) begin
        job.has_final = 1'b1;
        job.final_cp  = part_shift;
      end else if (in_end) begin
        // lead, held continuations and this one
        job.rep_cnt = held_inc + 2'd1;
      end else begin
        exp_len_nxt = exp_len_r;
        held_nxt    = held_inc;
        part_nxt    = part_shift;
      end
    end else begin
      if (seq_open) begin
        job.rep_cnt = held_r + 2'd1;
      end
      // byte is taken as a new lead
      if (!in_byte[7]) begin
        job.has_final = 1'b1;
        job.final_cp  = {13'd0, in_byte};
      end else if (lead_len == utf8d_pkg::LEN_NONE || in_end) begin
        job.has_final = 1'b1;
        job.final_rep = 1'b1;
      end else begin
        exp_len_nxt = lead_len;
        part_nxt    = lead_bits;
      end
    end
  end

  assign job_push = accept && (job.has_final || (job.rep_cnt != '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r <= utf8d_pkg::LEN_NONE;
      held_r    <= '0;
      part_r    <= '0;
    end else if (accept) begin
      exp_len_r <= exp_len_nxt;
      held_r    <= held_nxt;
      part_r    <= part_nxt;
    end
  end

endmodule

[rtl/utf8d_back.sv]
// Result back end: expands queued jobs into result transactions.
`timescale 1ns / 1ps
module utf8d_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_not_empty,
  input  utf8d_pkg::job_t            head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [utf8d_pkg::CpW-1:0]  out_cp,
  output logic                       out_rep,
  output logic                       out_last
);

  logic                       valid_r;
  logic [utf8d_pkg::CpW-1:0]  cp_r;
  logic                       rep_r, last_r;
  logic [1:0]                 sent_r, sent_nxt;

  logic                       load;
  logic [2:0]                 total;
  logic [1:0]                 last_idx;
  logic                       is_last;
  logic                       is_repl;

  assign total    = {1'b0, head.rep_cnt} + {2'b00, head.has_final};
  assign last_idx = 2'(total - 3'd1);
  assign is_last  = (sent_r == last_idx);
  assign is_repl  = (sent_r < head.rep_cnt);
  assign load     = q_not_empty && (!valid_r || out_ready);
  assign q_pop    = load && is_last;
  assign sent_nxt = is_last ? 2'd0 : sent_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sent_r  <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        sent_r  <= sent_nxt;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_r   <= is_repl ? utf8d_pkg::REPL_CP : head.final_cp;
      rep_r  <= is_repl ? 1'b1 : head.final_rep;
      last_r <= is_last;
    end
  end

  assign out_valid = valid_r;
  assign out_cp    = cp_r;
  assign out_rep   = rep_r;
  assign out_last  = last_r;

endmodule

[rtl/utf8_stream_decoder.sv]
// Top level of the UTF-8 stream decoder.
//
//  channel | direction | tdata                  | tuser    | tlast
//  in_     | slave     | [7:0] data_byte        | -        | text_end
//  out_    | master     | [20:0] code_point      | replaced | run_last
//
// One byte is accepted per cycle; a byte yields zero to four results, one per cycle
// from the output register while out_tready is high; its job is popped with the last one.
// Input stalls only when the job queue (QUEUE_DEPTH entries) is full.
// Reset (rst_n low, synchronous) closes any open sequence and empties queue and output.
// out_tready low freezes the output register; bytes keep flowing until the queue fills.
`timescale 1ns / 1ps
module utf8_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] zero
  output logic        out_tuser,  // [0] replaced
  output logic        out_tlast
);

  utf8d_pkg::job_t            push_job, head_job;
  logic                       push, pop, q_full, q_not_empty;
  logic [utf8d_pkg::JobW-1:0] head_bits;
  logic [utf8d_pkg::CpW-1:0]  cp;

  utf8d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_end   (in_tlast),
    .q_full   (q_full),
    .in_ready (in_tready),
    .job_push (push),
    .job      (push_job)
  );

  utf8d_fifo #(
    .WIDTH (utf8d_pkg::JobW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .head_data (head_bits),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  assign head_job = utf8d_pkg::job_t'(head_bits);

  utf8d_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .head        (head_job),
    .q_pop       (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_cp      (cp),
    .out_rep     (out_tuser),
    .out_last    (out_tlast)
  );

  assign out_tdata = {3'b000, cp};

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the UTF-8 stream decoder: directed and random byte streams.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 20;
  localparam int unsigned RandomBytes   = 120;
  localparam int unsigned CalmBytes     = 50;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [20:0] code_point, [23:21] zero
  logic        out_tuser;  // [0] replaced
  logic        out_tlast;

  typedef struct {
    logic [utf8d_pkg::CpW-1:0] cp;
    logic                      rep;
    logic                      last;
  } cp_result_t;

  cp_result_t pending_cp_q[$];
  cp_result_t cp_exp;

  // decoder state as the predictor sees it
  logic [2:0]                seq_len;
  logic [1:0]                cont_held;
  logic [utf8d_pkg::CpW-1:0] acc_cp;

  int unsigned n_bytes;
  int unsigned n_cps;
  int unsigned n_repl;
  int unsigned n_errors;
  int unsigned quiet_cycles;
  bit          sender_idles;
  bit          receiver_stalls;

  utf8_stream_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void note_cp(input logic [utf8d_pkg::CpW-1:0] cp, input logic rep);
    cp_result_t r;
    r.cp   = cp;
    r.rep  = rep;
    r.last = 1'b0;
    pending_cp_q.insert(pending_cp_q.size(), r);
  endfunction

  function automatic void close_sequence();
    seq_len   = utf8d_pkg::LEN_NONE;
    cont_held = 2'd0;
    acc_cp    = '0;
  endfunction

  // Works out the code points one accepted byte causes and queues them.
  function automatic void decode_byte(input logic [7:0] b, input logic fin);
    int unsigned               first;
    int unsigned               k;
    bit                        consumed;
    logic [2:0]                lead_len;
    logic [utf8d_pkg::CpW-1:0] lead_bits;
    first    = pending_cp_q.size();
    consumed = 1'b0;
    if (seq_len != utf8d_pkg::LEN_NONE) begin
      if (b[7:6] == 2'b10) begin
        acc_cp    = {acc_cp[utf8d_pkg::CpW-7:0], b[5:0]};
        cont_held = cont_held + 2'd1;
        if ({1'b0, cont_held} == seq_len - 3'd1) begin
          note_cp(acc_cp, 1'b0);
          close_sequence();
        end else if (fin) begin
          // lead, earlier continuations and this one
          for (k = 0; k <= cont_held; k++) note_cp(utf8d_pkg::REPL_CP, 1'b1);
          close_sequence();
        end
        consumed = 1'b1;
      end else begin
        for (k = 0; k <= cont_held; k++) note_cp(utf8d_pkg::REPL_CP, 1'b1);
        close_sequence();
      end
    end
    if (!consumed) begin
      if (!b[7]) begin
        note_cp({13'd0, b}, 1'b0);
      end else begin
        lead_len  = utf8d_pkg::LEN_NONE;
        lead_bits = '0;
        casez (b)
          8'b110?????: begin
            lead_len  = utf8d_pkg::LEN_TWO;
            lead_bits = {16'd0, b[4:0]};
          end
          8'b1110????: begin
            lead_len  = utf8d_pkg::LEN_THREE;
            lead_bits = {17'd0, b[3:0]};
          end
          8'b11110???: begin
            lead_len  = utf8d_pkg::LEN_FOUR;
            lead_bits = {18'd0, b[2:0]};
          end
          default: lead_len = utf8d_pkg::LEN_NONE;
        endcase
        if (lead_len == utf8d_pkg::LEN_NONE || fin) begin
          note_cp(utf8d_pkg::REPL_CP, 1'b1);
        end else begin
          seq_len   = lead_len;
          cont_held = 2'd0;
          acc_cp    = lead_bits;
        end
      end
    end
    if (pending_cp_q.size() > first) pending_cp_q[$].last = 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    n_bytes++;
    decode_byte(b, fin);
  endtask

  // Lead of the given length followed by nbytes-1 continuations; fin on the last byte sent.
  task automatic send_char(input int unsigned len, input int unsigned nbytes, input logic fin);
    logic [7:0]  lead;
    int unsigned k;
    case (len)
      1:       lead = {1'b0, 7'($urandom_range(0, 127))};
      2:       lead = {3'b110, 5'($urandom_range(0, 31))};
      3:       lead = {4'b1110, 4'($urandom_range(0, 15))};
      default: lead = {5'b11110, 3'($urandom_range(0, 7))};
    endcase
    send_byte(lead, fin && nbytes == 1);
    for (k = 1; k < nbytes; k++)
      send_byte({2'b10, 6'($urandom_range(0, 63))}, fin && k == nbytes - 1);
  endtask

  task automatic test_plain_ascii();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h41, 1'b1);
  endtask

  task automatic test_multibyte();
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA9, 1'b0);
    // a well-formed U+FFFD is not a replacement
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBD, 1'b0);
    // largest value a 4-byte sequence can spell
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_malformed();
    send_byte(8'h80, 1'b0);   // stray continuation
    send_byte(8'hFF, 1'b0);   // invalid lead
    send_byte(8'hE2, 1'b0);   // broken by an ASCII byte
    send_byte(8'h82, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hF0, 1'b0);   // broken by a new lead, which then completes
    send_byte(8'h9F, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hF0, 1'b0);   // text ends inside a sequence
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b1);
    send_byte(8'hC3, 1'b1);   // text ends on a lead
    send_byte(8'hA9, 1'b0);   // new text: stray continuation
  endtask

  // Sender holds off mid-sequence until the decoder has drained.
  task automatic test_drain_midsequence();
    send_byte(8'h24, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    in_tvalid <= 1'b0;
    wait (pending_cp_q.size() == 0);
    @(posedge clk);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  task automatic test_random_text();
    int unsigned stop_at;
    int unsigned calm_at;
    int unsigned pick;
    int unsigned len;
    logic        fin;
    stop_at = n_bytes + RandomBytes;
    calm_at = stop_at - CalmBytes;
    while (n_bytes < stop_at) begin
      if (n_bytes >= calm_at) begin
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
      end
      pick = $urandom_range(0, 99);
      fin  = ($urandom_range(0, 7) == 0);
      len  = $urandom_range(2, 4);
      if (pick < 30)      send_char(1, 1, fin);
      else if (pick < 80) send_char(len, len, fin);
      else if (pick < 87) send_byte({2'b10, 6'($urandom_range(0, 63))}, fin);
      else if (pick < 91) send_byte({5'b11111, 3'($urandom_range(0, 7))}, fin);
      else if (pick < 97) send_char(len, $urandom_range(1, len - 1), fin);  // truncated
      else                send_byte(8'($urandom_range(0, 255)), fin);
    end
  endtask

  task automatic finish_run();
    in_tvalid <= 1'b0;
    wait (pending_cp_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    $display("Decoded %0d bytes into %0d code points, %0d of them replacements,",
             n_bytes, n_cps, n_repl);
    $display("covering every lead length, broken and truncated sequences and stalls.");
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_cps++;
      if (out_tuser) n_repl++;
      if (pending_cp_q.size() == 0) begin
        $error("unexpected transaction: code_point %h replaced %b run_last %b",
               out_tdata[utf8d_pkg::CpW-1:0], out_tuser, out_tlast);
        n_errors++;
      end else begin
        cp_exp = pending_cp_q.pop_front();
        if (out_tdata[utf8d_pkg::CpW-1:0] !== cp_exp.cp) begin
          $error("code_point: expected %h, got %h", cp_exp.cp,
                 out_tdata[utf8d_pkg::CpW-1:0]);
          n_errors++;
        end
        if (out_tuser !== cp_exp.rep) begin
          $error("replaced: expected %b, got %b", cp_exp.rep, out_tuser);
          n_errors++;
        end
        if (out_tlast !== cp_exp.last) begin
          $error("run_last: expected %b, got %b", cp_exp.last, out_tlast);
          n_errors++;
        end
        if (out_tdata[23:utf8d_pkg::CpW] !== '0) begin
          $error("tdata pad: expected 0, got %b", out_tdata[23:utf8d_pkg::CpW]);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("Timeout: no transaction for %0d cycles", WatchdogLimit);
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver back-pressure in random bursts
  initial begin
    out_tready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (receiver_stalls && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = 8'h00;
    in_tlast        = 1'b0;
    n_bytes         = 0;
    n_cps           = 0;
    n_repl          = 0;
    n_errors        = 0;
    quiet_cycles    = 0;
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    close_sequence();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_plain_ascii();
    test_multibyte();
    test_malformed();
    test_drain_midsequence();
    test_random_text();
    finish_run();
  end

endmodule

[files.f]
rtl/utf8d_pkg.sv
rtl/utf8d_fifo.sv
rtl/utf8d_front.sv
rtl/utf8d_back.sv
rtl/utf8_stream_decoder.sv
sim/tb_top.sv
